// ===== rtl/drpt_pkg.sv =====
// ============================================================================
// drpt_pkg: shared types and constants of the dead-reckoning pose tracker
// Pose formats, command codes, trig table and the stream payload layout.
// ============================================================================
package drpt_pkg;

    // Angles in whole degrees
    localparam int unsigned FULL_TURN    = 360;
    localparam int unsigned HALF_TURN    = 180;
    localparam int unsigned QUARTER_TURN = 90;
    localparam int unsigned DEG_BITS     = 9;

    // Q1.15 trig magnitudes, 1.0 = 32768
    localparam int unsigned MAG_BITS  = 16;
    localparam int unsigned FRAC_BITS = 15;

    // Q33.15 position accumulators
    localparam int unsigned ACC_BITS = 48;
    localparam int unsigned POS_BITS = 32;

    // Duration width range and the widest duration the remainder unit takes
    localparam int unsigned DURATION_BITS_DEF = 16;
    localparam int unsigned DUR_MAX_BITS      = 32;

    // Output payload: x_pos, y_pos, heading, padded to whole bytes
    localparam int unsigned OUT_FIELD_BITS = 2 * POS_BITS + DEG_BITS;
    localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    // Input sideband: kind in bit 0, direction in bit 1
    localparam int unsigned IN_USER_BITS = 2;
    localparam int unsigned USER_KIND    = 0;
    localparam int unsigned USER_DIR     = 1;

    typedef logic [DEG_BITS-1:0] deg_t;
    typedef logic [MAG_BITS-1:0] mag_t;
    typedef logic [ACC_BITS-1:0] acc_t;

    typedef enum logic {
        KIND_MOVE   = 1'b0,
        KIND_ROTATE = 1'b1
    } kind_t;

    // Move: forward / backward; rotate: right (plus) / left (minus)
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    // Signed trig pair for the current heading
    typedef struct packed {
        logic cos_neg;
        mag_t cos_mag;
        logic sin_neg;
        mag_t sin_mag;
    } trig_t;

    localparam mag_t MAG_ONE = mag_t'(1 << FRAC_BITS);

    // Heading zero: cos = +1.0, sin = 0
    localparam trig_t TRIG_RESET = '{cos_neg: 1'b0, cos_mag: MAG_ONE,
                                     sin_neg: 1'b0, sin_mag: '0};

    // round(32768 * sin(k deg)) for k = 0..90
    localparam mag_t QUARTER_SINE [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

endpackage

// ===== rtl/dead_reckoning_pose_tracker_unit.sv =====
// ============================================================================
// dead_reckoning_pose_tracker_unit: dead-reckoning pose tracker
// Integrates move / rotate commands into a Q33.15 (x, y) position and a
// whole-degree heading, and reports the pose after every command.
// ============================================================================
//
//  Channel | Dir | Beat contents
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tuser: kind, direction; tdata: duration
//  m_*     | out | tdata: x_pos, y_pos, heading (one beat per command)
//
//  From input beat to result: the input register (which also
//  holds the duration reduced modulo 360), then the pose update that
//  writes the pose registers and marks the result valid.
//  One command per cycle sustained while m_tready stays high; the heading -> cos/sin table ->
//  multiply -> 48-bit add path is cut by registering cos/sin with the heading.
//  rst_n clears the pose to (0, 0, 0 deg) and empties both stages.
//  A stalled result holds the pose; the input register still takes a beat
//  while the result slot waits, then s_tready drops.
//
module dead_reckoning_pose_tracker_unit
    import drpt_pkg::*;
#(
    parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [DURATION_BITS-1:0] duration, zero padding above
    input  logic [((DURATION_BITS + 7) / 8) * 8-1:0] s_tdata,
    // [0] kind, [1] direction
    input  logic [IN_USER_BITS-1:0]                s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] x_pos, [63:32] y_pos, [72:64] heading, zero padding above
    output logic [OUT_DATA_BITS-1:0]               m_tdata
);

    localparam int unsigned PROD_BITS = DURATION_BITS + MAG_BITS;

    // Input stage
    logic                     s1_valid_reg;
    kind_t                    s1_kind_reg;
    logic                     s1_dir_reg;
    logic [DURATION_BITS-1:0] s1_dur_reg;
    deg_t                     s1_step_reg;

    // Pose state
    acc_t                     x_accum_reg, x_accum_next;
    acc_t                     y_accum_reg, y_accum_next;
    deg_t                     heading_reg, heading_next;
    trig_t                    trig_reg, trig_next;
    logic                     out_valid_reg;

    logic [DURATION_BITS-1:0] in_dur;
    deg_t                     in_step;
    logic                     out_free;
    logic                     advance;
    logic [PROD_BITS-1:0]     prod_x, prod_y;
    logic                     neg_x, neg_y;

    assign in_dur = s_tdata[DURATION_BITS-1:0];

    // Duration modulo 360 for rotations, taken before the input register
    drpt_mod360 u_mod360
    (
        .value (DUR_MAX_BITS'(in_dur)),
        .rem   (in_step)
    );

    // Handshake: stage 1 moves on when the result slot is empty or being read
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_kind_reg <= kind_t'(s_tuser[USER_KIND]);
            s1_dir_reg  <= s_tuser[USER_DIR];
            s1_dur_reg  <= in_dur;
            s1_step_reg <= in_step;
        end
    end

    // Heading update for rotations, wrapped into 0..359
    always_comb
    begin
        if (s1_dir_reg == DIR_REV)
        begin
            if (heading_reg >= s1_step_reg)
                heading_next = heading_reg - s1_step_reg;
            else
                heading_next = heading_reg + deg_t'(FULL_TURN) - s1_step_reg;
        end
        else
        begin
            if (10'(heading_reg) + 10'(s1_step_reg) >= 10'(FULL_TURN))
                heading_next = heading_reg + s1_step_reg - deg_t'(FULL_TURN);
            else
                heading_next = heading_reg + s1_step_reg;
        end
    end

    drpt_trig u_trig
    (
        .angle (heading_next),
        .trig  (trig_next)
    );

    // Displacement along the current heading; backward flips both signs
    assign prod_x = s1_dur_reg * trig_reg.cos_mag;
    assign prod_y = s1_dur_reg * trig_reg.sin_mag;
    assign neg_x  = trig_reg.cos_neg ^ (s1_dir_reg == DIR_REV);
    assign neg_y  = trig_reg.sin_neg ^ (s1_dir_reg == DIR_REV);

    always_comb
    begin
        x_accum_next = neg_x ? x_accum_reg - ACC_BITS'(prod_x) : x_accum_reg + ACC_BITS'(prod_x);
        y_accum_next = neg_y ? y_accum_reg - ACC_BITS'(prod_y) : y_accum_reg + ACC_BITS'(prod_y);
    end

    // Pose registers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_accum_reg   <= '0;
            y_accum_reg   <= '0;
            heading_reg   <= '0;
            trig_reg      <= TRIG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (s1_kind_reg == KIND_ROTATE)
                begin
                    heading_reg <= heading_next;
                    trig_reg    <= trig_next;
                end
                else
                begin
                    x_accum_reg <= x_accum_next;
                    y_accum_reg <= y_accum_next;
                end
            end
            if (out_free)
                out_valid_reg <= advance;
        end
    end

    // Pose only changes when a new result is loaded, so it is the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}},
                       heading_reg,
                       y_accum_reg[FRAC_BITS +: POS_BITS],
                       x_accum_reg[FRAC_BITS +: POS_BITS]};

    // Heading stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < deg_t'(FULL_TURN))
        else $error("heading out of range");

    // A held result keeps the pose unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(x_accum_reg) && $stable(y_accum_reg)
                                       && $stable(heading_reg))
        else $error("pose changed under a stalled result");

    // Rotations leave the position alone
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_kind_reg == KIND_ROTATE |=> $stable(x_accum_reg) && $stable(y_accum_reg))
        else $error("rotation moved the position");

    // Moves leave the heading and trig pair alone
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_kind_reg == KIND_MOVE |=> $stable(heading_reg) && $stable(trig_reg))
        else $error("move changed the heading");

    // Reduced rotation step is below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_step_reg < deg_t'(FULL_TURN))
        else $error("rotation step not reduced");

    // Trig magnitudes never exceed 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        trig_reg.cos_mag <= MAG_ONE && trig_reg.sin_mag <= MAG_ONE)
        else $error("trig magnitude above one");

endmodule

// ===== rtl/drpt_mod360.sv =====
// ============================================================================
// drpt_mod360: remainder of a duration modulo one full turn
// Folds the value byte by byte through constant residue tables, then folds
// the partial sum once more and finishes with a single compare and subtract.
// ============================================================================
module drpt_mod360
    import drpt_pkg::*;
(
    input  logic [DUR_MAX_BITS-1:0] value,
    output deg_t                    rem
);

    typedef logic [255:0][DEG_BITS-1:0] res_tab_t;

    // Residue of (i * weight) modulo a full turn, i = 0..255
    function automatic res_tab_t build_tab(input int unsigned weight);
        res_tab_t tab;
        for (int unsigned i = 0; i < 256; i++)
        begin
            tab[i] = DEG_BITS'((i * weight) % FULL_TURN);
        end
        return tab;
    endfunction

    localparam int unsigned W1 = (1 << 8) % FULL_TURN;
    localparam int unsigned W2 = (1 << 16) % FULL_TURN;
    localparam int unsigned W3 = (1 << 24) % FULL_TURN;

    localparam res_tab_t TAB1 = build_tab(W1);
    localparam res_tab_t TAB2 = build_tab(W2);
    localparam res_tab_t TAB3 = build_tab(W3);

    localparam int unsigned SUM1_BITS = 11;   // <= 255 + 3 * 359
    localparam int unsigned SUM2_BITS = 10;   // <= 255 + 359

    logic [SUM1_BITS-1:0] sum1;
    logic [SUM2_BITS-1:0] sum2;

    // First fold: four bytes weighted by 2^(8k) mod 360
    assign sum1 = SUM1_BITS'(value[7:0])
                + SUM1_BITS'(TAB1[value[15:8]])
                + SUM1_BITS'(TAB2[value[23:16]])
                + SUM1_BITS'(TAB3[value[31:24]]);

    // Second fold: low byte plus residue of the upper three bits
    assign sum2 = SUM2_BITS'(sum1[7:0]) + SUM2_BITS'(TAB1[{5'b0, sum1[10:8]}]);

    // Final correction, sum2 < 2 * 360
    assign rem = (sum2 >= SUM2_BITS'(FULL_TURN)) ? DEG_BITS'(sum2 - SUM2_BITS'(FULL_TURN))
                                                  : DEG_BITS'(sum2);

endmodule

// ===== rtl/drpt_trig.sv =====
// ============================================================================
// drpt_trig: signed cosine and sine of a whole-degree heading
// Quadrant split plus quarter-wave table lookup, Q1.15 magnitudes.
// ============================================================================
module drpt_trig
    import drpt_pkg::*;
(
    input  deg_t  angle,
    output trig_t trig
);

    // Sine of a in 0..359: magnitude and negative flag
    function automatic logic [MAG_BITS:0] sine_of(input deg_t a);
        deg_t       rem;
        logic       odd;
        logic       neg;
        logic [6:0] idx;
        if (a < deg_t'(QUARTER_TURN))
        begin
            rem = a;
            odd = 1'b0;
            neg = 1'b0;
        end
        else if (a < deg_t'(HALF_TURN))
        begin
            rem = a - deg_t'(QUARTER_TURN);
            odd = 1'b1;
            neg = 1'b0;
        end
        else if (a < deg_t'(HALF_TURN + QUARTER_TURN))
        begin
            rem = a - deg_t'(HALF_TURN);
            odd = 1'b0;
            neg = 1'b1;
        end
        else
        begin
            rem = a - deg_t'(HALF_TURN + QUARTER_TURN);
            odd = 1'b1;
            neg = 1'b1;
        end
        idx = odd ? 7'(deg_t'(QUARTER_TURN) - rem) : rem[6:0];
        return {neg, QUARTER_SINE[idx]};
    endfunction

    deg_t              cos_angle;
    logic [MAG_BITS:0] cos_val;
    logic [MAG_BITS:0] sin_val;

    // cos(a) = sin(a + 90), wrapped into 0..359
    always_comb
    begin
        if (angle >= deg_t'(FULL_TURN - QUARTER_TURN))
            cos_angle = angle - deg_t'(FULL_TURN - QUARTER_TURN);
        else
            cos_angle = angle + deg_t'(QUARTER_TURN);
    end

    assign cos_val = sine_of(cos_angle);
    assign sin_val = sine_of(angle);

    assign trig.cos_neg = cos_val[MAG_BITS];
    assign trig.cos_mag = cos_val[MAG_BITS-1:0];
    assign trig.sin_neg = sin_val[MAG_BITS];
    assign trig.sin_mag = sin_val[MAG_BITS-1:0];

endmodule

// ===== sim/drpt_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// drpt_checker: pose scoreboard for the dead-reckoning pose tracker
// Watches the command and result channels. Each accepted command beat is run
// through a local pose model, and the pose it yields is queued. Each accepted
// result beat is compared with the oldest queued pose.
// ============================================================================
module drpt_checker
    import drpt_pkg::*;
#(
    parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    // [DURATION_BITS-1:0] duration, zero padding above
    input  logic [((DURATION_BITS + 7) / 8) * 8-1:0] s_tdata,
    // [0] kind, [1] direction
    input  logic [IN_USER_BITS-1:0]                s_tuser,

    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] x_pos, [63:32] y_pos, [72:64] heading, zero padding above
    input  logic [OUT_DATA_BITS-1:0]               m_tdata,

    output int unsigned                            fail_count,
    output int unsigned                            poses_due
);

    typedef logic [DURATION_BITS-1:0] dur_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] x_pos;
        logic signed [POS_BITS-1:0] y_pos;
        deg_t                       heading;
    } pose_t;

    // Local copy of the tracked pose
    acc_t        track_x;
    acc_t        track_y;
    deg_t        track_heading;
    pose_t       pose_queue[$];
    int unsigned mismatches;

    // Signed sine of a whole-degree angle from the quarter-wave table
    function automatic void sine_of(input int unsigned deg, output mag_t mag,
                                    output logic neg);
        int unsigned angle;
        int unsigned quadrant;
        int unsigned offset;
        angle    = deg % FULL_TURN;
        quadrant = angle / QUARTER_TURN;
        offset   = angle % QUARTER_TURN;
        neg      = (quadrant >= 2);
        mag      = QUARTER_SINE[quadrant[0] ? QUARTER_TURN - offset : offset];
    endfunction

    // One axis of a move: exact product, wrapping 48-bit add or subtract
    function automatic acc_t shift_axis(acc_t acc, dur_t dur, mag_t mag, logic neg);
        acc_t delta;
        delta = acc_t'(dur) * acc_t'(mag);
        return neg ? acc - delta : acc + delta;
    endfunction

    // Applies one command to the local pose and returns the pose after it
    function automatic pose_t advance_pose(kind_t kind, logic dir, dur_t dur);
        mag_t        cos_mag;
        mag_t        sin_mag;
        logic        cos_neg;
        logic        sin_neg;
        int unsigned turn;
        pose_t       pose;
        if (kind == KIND_MOVE)
        begin
            sine_of(track_heading + QUARTER_TURN, cos_mag, cos_neg);
            sine_of(track_heading, sin_mag, sin_neg);
            // backward: displacement is subtracted
            if (dir == DIR_REV)
            begin
                cos_neg = !cos_neg;
                sin_neg = !sin_neg;
            end
            track_x = shift_axis(track_x, dur, cos_mag, cos_neg);
            track_y = shift_axis(track_y, dur, sin_mag, sin_neg);
        end
        else
        begin
            turn = dur % FULL_TURN;
            if (dir == DIR_REV)
                track_heading = deg_t'((track_heading + FULL_TURN - turn) % FULL_TURN);
            else
                track_heading = deg_t'((track_heading + turn) % FULL_TURN);
        end
        pose.x_pos   = track_x[FRAC_BITS +: POS_BITS];
        pose.y_pos   = track_y[FRAC_BITS +: POS_BITS];
        pose.heading = track_heading;
        return pose;
    endfunction

    // Result beats are checked before the command beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        pose_t got;
        if (!rst_n)
        begin
            track_x       = '0;
            track_y       = '0;
            track_heading = '0;
            pose_queue.delete();
            mismatches    = 0;
            fail_count   <= 0;
            poses_due    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.x_pos   = m_tdata[0 +: POS_BITS];
                got.y_pos   = m_tdata[POS_BITS +: POS_BITS];
                got.heading = m_tdata[2 * POS_BITS +: DEG_BITS];
                if (pose_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no command pending: x=%0d y=%0d h=%0d",
                                 $realtime, got.x_pos, got.y_pos, got.heading);
                end
                else
                begin
                    want = pose_queue.pop_front();
                    if (got.x_pos !== want.x_pos || got.y_pos !== want.y_pos ||
                        got.heading !== want.heading)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                                     $realtime,
                                     want.x_pos, want.y_pos, want.heading,
                                     got.x_pos, got.y_pos, got.heading);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pose_queue.push_back(advance_pose(kind_t'(s_tuser[USER_KIND]),
                                                  s_tuser[USER_DIR],
                                                  dur_t'(s_tdata)));
            fail_count <= mismatches;
            poses_due  <= pose_queue.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for the dead-reckoning pose tracker
// Sends directed move / rotate commands, then random commands with random
// gaps on both channels. The checker scores each pose.
// ============================================================================
module tb_top;
    import drpt_pkg::*;

    localparam int unsigned IN_DATA_BITS = ((DURATION_BITS_DEF + 7) / 8) * 8;
    localparam int unsigned RANDOM_CMDS  = 1400;

    typedef logic [DURATION_BITS_DEF-1:0] dur_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic [IN_USER_BITS-1:0]  s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    int unsigned              fail_count;
    int unsigned              poses_due;

    // Set while both channels run without gaps
    bit                       calm = 1'b0;

    always #10 clk = ~clk;

    dead_reckoning_pose_tracker_unit #(
        .DURATION_BITS (DURATION_BITS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    drpt_checker #(
        .DURATION_BITS (DURATION_BITS_DEF)
    ) pose_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .poses_due  (poses_due)
    );

    // One command beat, after a random gap; returns once it is accepted
    task automatic send_cmd(input kind_t kind, input logic dir, input dur_t dur);
        int unsigned             gap;
        logic [IN_USER_BITS-1:0] user;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        user           = '0;
        user[USER_KIND] = kind;
        user[USER_DIR]  = dir;
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= IN_DATA_BITS'(dur);
        do @(posedge clk); while (!s_tready);
    endtask

    // Durations weighted toward the extremes and short values
    function automatic dur_t pick_duration();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return dur_t'($urandom_range(0, 400));
            default: return dur_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: random stall before each beat
    initial
    begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Command side and verdict
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero and full durations, all four quadrants, heading wraps
        send_cmd(KIND_MOVE,   DIR_FWD, '0);
        send_cmd(KIND_MOVE,   DIR_FWD, '1);
        send_cmd(KIND_MOVE,   DIR_REV, '1);
        send_cmd(KIND_MOVE,   DIR_REV, dur_t'(1));      // x goes below zero
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(90));
        send_cmd(KIND_MOVE,   DIR_FWD, dur_t'(1000));
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(90));
        send_cmd(KIND_MOVE,   DIR_FWD, '1);
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(90));
        send_cmd(KIND_MOVE,   DIR_REV, dur_t'(300));
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(89));      // 359
        send_cmd(KIND_MOVE,   DIR_FWD, dur_t'(7));
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(1));       // reaches 360, wraps to 0
        send_cmd(KIND_ROTATE, DIR_REV, dur_t'(1));       // below 0, wraps to 359
        send_cmd(KIND_ROTATE, DIR_FWD, '0);
        send_cmd(KIND_ROTATE, DIR_FWD, '1);              // large turn right
        send_cmd(KIND_ROTATE, DIR_REV, '1);              // large turn left
        send_cmd(KIND_ROTATE, DIR_REV, dur_t'(FULL_TURN));
        send_cmd(KIND_ROTATE, DIR_REV, dur_t'(FULL_TURN - 1));
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(2 * FULL_TURN));
        send_cmd(KIND_ROTATE, DIR_FWD, dur_t'(HALF_TURN / 4));  // 45 deg
        send_cmd(KIND_MOVE,   DIR_FWD, '1);
        send_cmd(KIND_MOVE,   DIR_REV, '0);

        // Random commands, with stretches of gap-free traffic
        repeat (RANDOM_CMDS)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            send_cmd(kind_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     pick_duration());
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain, then let the pipeline settle; the checker count is registered, so it lags
        @(posedge clk);
        while (poses_due != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && poses_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
